/* hw/rtl/sfs_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_pkg
// Shared types and codes of the sprite frame sequencer.
// ----------------------------------------------------------------------------
package sfs_pkg;

	localparam int MAX_FRAMES_DEF = 256;

	localparam int CMD_W   = 3;
	localparam int STAMP_W = 32;
	localparam int FIDX_W  = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int FCOUNT_W   = 9;

	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_TICK   = 3'd0;
	localparam cmd_t CMD_START  = 3'd1;
	localparam cmd_t CMD_STOP   = 3'd2;
	localparam cmd_t CMD_PAUSE  = 3'd3;
	localparam cmd_t CMD_REWIND = 3'd4;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_TOTAL_RUN_TIME = 2'd0;
	localparam cfg_idx_t CFG_LOOP_ENABLE    = 2'd1;
	localparam cfg_idx_t CFG_FRAME_COUNT    = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage : sfs_pkg
`default_nettype wire

/* hw/rtl/sfs_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sfs_if
// Valid/ready channels of the sprite frame sequencer: command in, frame out.
// ----------------------------------------------------------------------------
interface sfs_in_if;
	logic                         valid;
	logic                         ready;
	logic [sfs_pkg::CMD_W-1:0]    command;
	logic [sfs_pkg::STAMP_W-1:0]  time_now;

	modport source (output valid, output command, output time_now, input ready);
	modport sink   (input valid, input command, input time_now, output ready);
endinterface : sfs_in_if

interface sfs_out_if;
	logic                         valid;
	logic                         ready;
	logic [sfs_pkg::FIDX_W-1:0]   frame_index;
	logic                         changed;
	logic                         running;

	modport source (output valid, output frame_index, output changed, output running,
		input ready);
	modport sink   (input valid, input frame_index, input changed, input running,
		output ready);
endinterface : sfs_out_if
`default_nettype wire

/* hw/rtl/sprite_frame_sequencer_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sprite_frame_sequencer_unit
// Advances a sprite animation's frame index from millisecond tick stamps,
// with start/stop/pause/rewind commands. Frame time is total_run_time
// divided by (frame count - 1), computed per tick by a bit-serial divider.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  in_ch     in   valid/ready        command[2:0], time_now[31:0]
//  out_ch    out  valid/ready        frame_index[7:0], changed, running
//  cfg       in   cfg_we (no stall)  cfg_index[1:0], cfg_data[31:0]
//
//  A tick that needs the frame time (frames > 1, previous stamp nonzero,
//  running) goes through accept, 32 restoring divide steps through one
//  shared subtract/compare unit, and commit. Every other transaction
//  goes from accept straight to commit.
//  in_ch.ready is high only while the sequencer is idle.
//  Commit waits while a previous result is still held on out_ch.
//  arst_n resets state (run and changed set), config and the output slot; no clearing pass.
// ----------------------------------------------------------------------------
module sprite_frame_sequencer_unit #(
	parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	sfs_in_if.sink                                in_ch,
	sfs_out_if.source                             out_ch,
	input  wire logic                             cfg_we,
	input  wire logic [sfs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sfs_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import sfs_pkg::*;

	// frame count register is 9 bits, so the clamp never exceeds 511
	localparam int CNT_MAX = (MAX_FRAMES < 511) ? MAX_FRAMES : 511;
	localparam int FW      = $clog2(CNT_MAX + 1);
	localparam int STEP_W  = $clog2(STAMP_W);

	// configuration
	logic [STAMP_W-1:0]  total_q;
	logic                loop_q;
	logic [FCOUNT_W-1:0] fcount_q;

	// animation state
	logic [STAMP_W-1:0]  last_stamp_q;
	logic [STAMP_W-1:0]  elapsed_q;
	logic [FW-1:0]       cur_frame_q;
	logic                run_q;
	logic                dirty_q;

	// latched transaction
	cmd_t                cmd_q;
	logic [STAMP_W-1:0]  now_q;

	// divider
	logic [STAMP_W-1:0]  quo_q;
	logic [FW-1:0]       rem_q;
	logic [STEP_W-1:0]   step_q;

	state_t              state_q, state_d;
	logic                out_valid_q;

	logic                accept;
	logic                commit;
	logic                div_step;
	logic                need_div;

	logic [FW-1:0]       n_cnt;
	logic [FW-1:0]       divisor;
	logic [FW:0]         trial;
	logic                trial_ge;

	logic [STAMP_W:0]    sum;
	logic [STAMP_W-1:0]  el_sat;
	logic [FW:0]         cf_inc;

	logic [STAMP_W-1:0]  last_stamp_d;
	logic [STAMP_W-1:0]  elapsed_d;
	logic [FW-1:0]       cur_frame_d;
	logic                run_d;
	logic                dirty_d;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q  <= '0;
			loop_q   <= 1'b0;
			fcount_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TOTAL_RUN_TIME: total_q  <= cfg_data;
				CFG_LOOP_ENABLE:    loop_q   <= cfg_data[0];
				CFG_FRAME_COUNT:    fcount_q <= cfg_data[FCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign n_cnt   = (fcount_q > FCOUNT_W'(CNT_MAX)) ? FW'(CNT_MAX) : FW'(fcount_q);
	assign divisor = n_cnt - FW'(1);

	// only a running tick with a valid previous stamp needs the frame time
	assign need_div = (in_ch.command == CMD_TICK) && (n_cnt > FW'(1)) &&
		(last_stamp_q != '0) && run_q;

	// ------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_ch.valid) state_d = need_div ? ST_DIV : ST_FIN;
			ST_DIV:  if (step_q == '0) state_d = ST_FIN;
			ST_FIN:  if (!out_valid_q || out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready = 1'b0;
		div_step    = 1'b0;
		commit      = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ch.ready = 1'b1;
			ST_DIV:  div_step    = 1'b1;
			ST_FIN:  commit      = !out_valid_q || out_ch.ready;
			default: ;
		endcase
	end

	assign accept = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_ch.command;
			now_q <= in_ch.time_now;
		end
	end

	// ---------------------------------------------------- restoring divider
	assign trial    = {rem_q, quo_q[STAMP_W-1]};
	assign trial_ge = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (accept) begin
			step_q <= STEP_W'(STAMP_W - 1);
		end else if (div_step) begin
			step_q <= step_q - STEP_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			quo_q <= total_q;
			rem_q <= '0;
		end else if (div_step) begin
			quo_q <= {quo_q[STAMP_W-2:0], trial_ge};
			rem_q <= trial_ge ? FW'(trial - {1'b0, divisor}) : trial[FW-1:0];
		end
	end

	// ---------------------------------------------------------- commit path
	assign sum    = {1'b0, elapsed_q} + {1'b0, now_q - last_stamp_q};
	assign el_sat = sum[STAMP_W] ? '1 : sum[STAMP_W-1:0];

	always_comb begin
		last_stamp_d = last_stamp_q;
		elapsed_d    = elapsed_q;
		cur_frame_d  = cur_frame_q;
		run_d        = run_q;
		dirty_d      = dirty_q;
		cf_inc       = {1'b0, cur_frame_q};
		case (cmd_q)
			CMD_TICK: begin
				if (n_cnt > FW'(1)) begin
					last_stamp_d = now_q;
					if (last_stamp_q == '0) begin
						dirty_d = 1'b1;
					end else begin
						dirty_d = 1'b0;
						if (run_q) begin
							elapsed_d = el_sat;
							if (el_sat >= quo_q) begin
								cf_inc    = {1'b0, cur_frame_q} + (FW+1)'(1);
								elapsed_d = '0;
								dirty_d   = 1'b1;
							end
							cur_frame_d = cf_inc[FW-1:0];
							if (cf_inc >= {1'b0, n_cnt}) begin
								if (loop_q) begin
									elapsed_d   = '0;
									cur_frame_d = '0;
									dirty_d     = 1'b1;
								end else begin
									run_d = 1'b0;
									if (cf_inc != {1'b0, divisor}) begin
										cur_frame_d = divisor;
										dirty_d     = 1'b1;
									end
								end
							end
						end
					end
				end
			end
			CMD_START:  run_d = 1'b1;
			CMD_STOP: begin
				run_d       = 1'b0;
				cur_frame_d = '0;
			end
			CMD_PAUSE:  run_d = 1'b0;
			CMD_REWIND: cur_frame_d = '0;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_stamp_q <= '0;
			elapsed_q    <= '0;
			cur_frame_q  <= '0;
			run_q        <= 1'b1;
			dirty_q      <= 1'b1;
		end else if (commit) begin
			last_stamp_q <= last_stamp_d;
			elapsed_q    <= elapsed_d;
			cur_frame_q  <= cur_frame_d;
			run_q        <= run_d;
			dirty_q      <= dirty_d;
		end
	end

	// state only moves at commit, which needs a free output slot, so the
	// state registers double as the result payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.frame_index = FIDX_W'(cur_frame_q);
	assign out_ch.changed     = dirty_q;
	assign out_ch.running     = run_q;

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ch.ready)
		else $error("new transaction accepted while busy");

	a_commit_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_valid_q && !out_ch.ready) |=> state_q == ST_FIN)
		else $error("commit over an untaken result");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q == '0) |=> state_q == ST_FIN)
		else $error("divider did not hand over to commit");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_frame_q < FW'(CNT_MAX))
		else $error("frame index beyond clamp");

	a_state_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!commit |=> $stable(cur_frame_q) && $stable(run_q) && $stable(dirty_q))
		else $error("state moved outside commit");
`endif

endmodule : sprite_frame_sequencer_unit
`default_nettype wire

/* dv/tb_sprite_frame_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// tb_sprite_frame_sequencer_unit
// Self-checking bench for the sprite frame sequencer. A short table of
// commands and register writes covers the corner cases. Random phases follow,
// with mostly well-formed tick streams. Every result transaction is checked
// against the table's expected value where it gives one, else against a
// cycle-free model of the frame stepping. The sender idles in bursts and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module tb_sprite_frame_sequencer_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import sfs_pkg::*;

	localparam int CLK_PERIOD     = 20;
	localparam int MAX_FRAMES     = MAX_FRAMES_DEF;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RAND_PHASES    = 12;
	localparam int PHASE_ITEMS    = 40;
	localparam int LONG_ITEMS     = 300;
	localparam int PLAN_ROWS      = 34;

	// command codes the block must ignore
	localparam cmd_t CMD_SPARE_LO = 3'd5;
	localparam cmd_t CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [FIDX_W-1:0] frame_index;
		logic              changed;
		logic              running;
	} frame_rsp_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		cmd_t                   op;
		cfg_idx_t               sel;
		logic [CFG_DATA_W-1:0]  value;
		logic                   known;
		frame_rsp_t             want;
	} plan_row_t;

	localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
		// no frames configured: ticks and spare codes leave the reset state
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd5, 1'b1, '{8'd0, 1'b1, 1'b1}},
		'{ROW_ITEM, CMD_SPARE_HI, CFG_TOTAL_RUN_TIME, 32'd0, 1'b1, '{8'd0, 1'b1, 1'b1}},
		'{ROW_CFG,  CMD_TICK,     CFG_FRAME_COUNT,    32'd1, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd9, 1'b1, '{8'd0, 1'b1, 1'b1}},
		// four frames, 10 ms each
		'{ROW_CFG,  CMD_TICK,     CFG_FRAME_COUNT,    32'd4, 1'b0, '0},
		'{ROW_CFG,  CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd30, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd0, 1'b1, '{8'd0, 1'b1, 1'b1}},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd100, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd115, 1'b0, '0},
		'{ROW_ITEM, CMD_PAUSE,    CFG_TOTAL_RUN_TIME, 32'd0, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd200, 1'b0, '0},
		'{ROW_ITEM, CMD_START,    CFG_TOTAL_RUN_TIME, 32'd0, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'hFFFF_FFFF, 1'b0, '0},
		// stamp wraps through zero
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd4, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd40, 1'b0, '0},
		// runs off the end without looping: holds last frame and pauses
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd50, 1'b0, '0},
		'{ROW_ITEM, CMD_STOP,     CFG_TOTAL_RUN_TIME, 32'd0, 1'b0, '0},
		'{ROW_ITEM, CMD_START,    CFG_TOTAL_RUN_TIME, 32'd0, 1'b0, '0},
		// zero frame time, looping: every running tick advances
		'{ROW_CFG,  CMD_TICK,     CFG_LOOP_ENABLE,    32'd1, 1'b0, '0},
		'{ROW_CFG,  CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd0, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd60, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd60, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd60, 1'b0, '0},
		// count lowered under the index, loop wraps to zero
		'{ROW_CFG,  CMD_TICK,     CFG_FRAME_COUNT,    32'd2, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd60, 1'b0, '0},
		// accumulator saturation against a full-scale frame time
		'{ROW_CFG,  CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'hFFFF_FFFF, 1'b0, '0},
		'{ROW_CFG,  CMD_TICK,     CFG_LOOP_ENABLE,    32'd0, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'hF000_0046, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'hE000_0046, 1'b0, '0},
		// count above the frame limit is clamped: 510 / 255 = 2 ms per frame
		'{ROW_CFG,  CMD_TICK,     CFG_FRAME_COUNT,    32'h1FF, 1'b0, '0},
		'{ROW_CFG,  CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'd510, 1'b0, '0},
		'{ROW_ITEM, CMD_REWIND,   CFG_TOTAL_RUN_TIME, 32'd0, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'hE000_0047, 1'b0, '0},
		'{ROW_ITEM, CMD_TICK,     CFG_TOTAL_RUN_TIME, 32'hE000_0048, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic                  cfg_we;
	cfg_idx_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sfs_in_if  in_ch ();
	sfs_out_if out_ch ();

	sprite_frame_sequencer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD/2) clk = ~clk;

	// register mirror
	logic [31:0]         cfg_total_ms;
	logic                cfg_loop;
	logic [FCOUNT_W-1:0] cfg_frames;

	// sequencer state
	logic [31:0]         seq_last_ms;
	logic [31:0]         seq_acc_ms;
	logic [FCOUNT_W-1:0] seq_frame;
	logic                seq_run;
	logic                seq_dirty;

	frame_rsp_t  pending_frames [$];
	int unsigned fault_count = 0;
	int unsigned burst_left  = 0;

	function automatic logic [FCOUNT_W-1:0] clamped_frames();
		return (cfg_frames > MAX_FRAMES) ? FCOUNT_W'(MAX_FRAMES) : cfg_frames;
	endfunction

	function automatic void seq_reset();
		cfg_total_ms = '0;
		cfg_loop     = 1'b0;
		cfg_frames   = '0;
		seq_last_ms  = '0;
		seq_acc_ms   = '0;
		seq_frame    = '0;
		seq_run      = 1'b1;
		seq_dirty    = 1'b1;
	endfunction

	function automatic frame_rsp_t seq_advance(cmd_t op, logic [31:0] now_ms);
		logic [FCOUNT_W-1:0] n_eff;
		logic [31:0]         frame_ms;
		logic [31:0]         gap_ms;
		frame_rsp_t          r;
		n_eff = clamped_frames();
		case (op)
		CMD_TICK: begin
			if (n_eff > 1) begin
				frame_ms = cfg_total_ms / 32'(n_eff - 1'b1);
				if (seq_last_ms == '0) begin
					seq_dirty = 1'b1;
				end else begin
					seq_dirty = 1'b0;
					if (seq_run) begin
						gap_ms = now_ms - seq_last_ms;
						if (seq_acc_ms > 32'hFFFF_FFFF - gap_ms)
							seq_acc_ms = 32'hFFFF_FFFF;
						else
							seq_acc_ms = seq_acc_ms + gap_ms;
						if (seq_acc_ms >= frame_ms) begin
							seq_frame  = seq_frame + 1'b1;
							seq_acc_ms = '0;
							seq_dirty  = 1'b1;
						end
						if (seq_frame >= n_eff) begin
							if (cfg_loop) begin
								seq_acc_ms = '0;
								seq_frame  = '0;
								seq_dirty  = 1'b1;
							end else begin
								seq_run = 1'b0;
								if (seq_frame != n_eff - 1'b1) begin
									seq_frame = n_eff - 1'b1;
									seq_dirty = 1'b1;
								end
							end
						end
					end
				end
				seq_last_ms = now_ms;
			end
		end
		CMD_START: seq_run = 1'b1;
		CMD_STOP: begin
			seq_run   = 1'b0;
			seq_frame = '0;
		end
		CMD_PAUSE:  seq_run = 1'b0;
		CMD_REWIND: seq_frame = '0;
		default: ;
		endcase
		r.frame_index = seq_frame[FIDX_W-1:0];
		r.changed     = seq_dirty;
		r.running     = seq_run;
		return r;
	endfunction

	// one transaction on the input channel, then the sender's idle pattern
	task automatic issue_command(cmd_t op, logic [31:0] now_ms, logic known, frame_rsp_t typed);
		frame_rsp_t pred;
		in_ch.valid    <= 1'b1;
		in_ch.command  <= op;
		in_ch.time_now <= now_ms;
		do @(posedge clk); while (!in_ch.ready);
		pred = seq_advance(op, now_ms);
		pending_frames = {pending_frames, (known ? typed : pred)};
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_ch.valid <= 1'b0;
			if ($urandom_range(0, 24) == 0) begin
				do @(posedge clk); while (pending_frames.size() != 0);
			end else begin
				repeat ($urandom_range(1, 40)) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
			                                         : $urandom_range(0, 6);
		end
	endtask

	task automatic drain_sequencer();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_frames.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_setting(cfg_idx_t sel, logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= value;
		@(posedge clk);
		case (sel)
		CFG_TOTAL_RUN_TIME: cfg_total_ms = value;
		CFG_LOOP_ENABLE:    cfg_loop     = value[0];
		CFG_FRAME_COUNT:    cfg_frames   = value[FCOUNT_W-1:0];
		default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin : frame_check
		frame_rsp_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_frames.size() == 0) begin
				$error("result transaction with no command pending");
				fault_count++;
			end else begin
				want = pending_frames.pop_front();
				if (out_ch.frame_index !== want.frame_index) begin
					$error("frame_index: expected %0d, got %0d",
						want.frame_index, out_ch.frame_index);
					fault_count++;
				end
				if (out_ch.changed !== want.changed) begin
					$error("changed: expected %0d, got %0d", want.changed, out_ch.changed);
					fault_count++;
				end
				if (out_ch.running !== want.running) begin
					$error("running: expected %0d, got %0d", want.running, out_ch.running);
					fault_count++;
				end
			end
		end
	end

	// receiver: cycles through always-ready, light, periodic and heavy stalls
	initial begin : rx_pattern
		logic [8:0] rx_step;
		rx_step = '0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rx_step = rx_step + 1'b1;
			case (rx_step[8:7])
			2'd0:    out_ch.ready <= 1'b1;
			2'd1:    out_ch.ready <= ($urandom_range(0, 3) != 0);
			2'd2:    out_ch.ready <= (rx_step[2:0] == 3'd0);
			default: out_ch.ready <= ($urandom_range(0, 9) > 6);
			endcase
		end
	end

	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		int unsigned         row, phase, k, items, r, tick_pct;
		logic [FCOUNT_W-1:0] n_eff;
		logic [31:0]         span, delta, wall_ms, now_ms;
		cmd_t                op;
		logic                long_run;
		arst_n         <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_index      <= CFG_TOTAL_RUN_TIME;
		cfg_data       <= '0;
		in_ch.valid    <= 1'b0;
		in_ch.command  <= CMD_TICK;
		in_ch.time_now <= '0;
		seq_reset();
		wall_ms = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < PLAN_ROWS; row++) begin
			if (PLAN[row].kind == ROW_CFG) begin
				drain_sequencer();
				load_setting(PLAN[row].sel, PLAN[row].value);
			end else begin
				issue_command(PLAN[row].op, PLAN[row].value, PLAN[row].known, PLAN[row].want);
			end
		end
		wall_ms = 32'hE000_0048;

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			drain_sequencer();
			long_run = (phase == RAND_PHASES / 2);
			if (long_run) begin
				// many frames, short frame time: walk the index up through 255 and wrap
				load_setting(CFG_FRAME_COUNT, $urandom_range(0, 1) ? 32'd256 : 32'h1FF);
				load_setting(CFG_TOTAL_RUN_TIME, $urandom_range(0, 500));
				load_setting(CFG_LOOP_ENABLE, 32'd1);
				issue_command(CMD_START, $urandom(), 1'b0, '0);
				items    = LONG_ITEMS;
				tick_pct = 100;
			end else begin
				r = $urandom_range(0, 9);
				if (r == 0)
					load_setting(CFG_FRAME_COUNT, $urandom_range(0, 1));
				else if (r == 1)
					load_setting(CFG_FRAME_COUNT, $urandom_range(256, 511));
				else
					load_setting(CFG_FRAME_COUNT, $urandom_range(2, 12));
				r = $urandom_range(0, 7);
				if (r == 0)
					load_setting(CFG_TOTAL_RUN_TIME, 32'd0);
				else if (r == 1)
					load_setting(CFG_TOTAL_RUN_TIME, 32'hFFFF_FFFF);
				else if (r == 2)
					load_setting(CFG_TOTAL_RUN_TIME, $urandom());
				else
					load_setting(CFG_TOTAL_RUN_TIME, $urandom_range(0, 400));
				load_setting(CFG_LOOP_ENABLE, $urandom_range(0, 1));
				items    = PHASE_ITEMS;
				tick_pct = 70;
			end

			for (k = 0; k < items; k++) begin
				if ($urandom_range(0, 99) < tick_pct) begin
					op    = CMD_TICK;
					n_eff = clamped_frames();
					span  = (n_eff > 1) ? cfg_total_ms / 32'(n_eff - 1'b1) : 32'd100;
					// stamps mostly advance by about one frame time
					r = $urandom_range(0, 99);
					if (r < 70)
						delta = (span > 32'h1000_0000) ? $urandom()
						                               : $urandom_range(0, span + (span >> 1));
					else if (r < 80)
						delta = '0;
					else
						delta = $urandom();
					if (r < 92)
						wall_ms = wall_ms + delta;
					else if (r < 96)
						wall_ms = '0;
					else
						wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 3);
					now_ms = wall_ms;
				end else begin
					case ($urandom_range(0, 9))
					0, 1, 2: op = CMD_START;
					3:       op = CMD_STOP;
					4:       op = CMD_PAUSE;
					5, 6:    op = CMD_REWIND;
					7:       op = cmd_t'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
					default: op = CMD_START;
					endcase
					now_ms = $urandom();
				end
				issue_command(op, now_ms, 1'b0, '0);
			end
		end

		drain_sequencer();
		if (fault_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule : tb_sprite_frame_sequencer_unit
